// ===== src/interval_timer_with_catchup_core_macros.svh =====
`ifndef INTERVAL_TIMER_WITH_CATCHUP_CORE_MACROS_SVH
`define INTERVAL_TIMER_WITH_CATCHUP_CORE_MACROS_SVH

// implication checked on every clock outside reset
`define ITC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ITC_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== src/itc_pkg.sv =====
package itc_pkg;

    localparam logic [3:0] OP_TICK      = 4'd0;
    localparam logic [3:0] OP_SET       = 4'd1;
    localparam logic [3:0] OP_ADD       = 4'd2;
    localparam logic [3:0] OP_TAKE      = 4'd3;
    localparam logic [3:0] OP_RESET     = 4'd4;
    localparam logic [3:0] OP_STOP      = 4'd5;
    localparam logic [3:0] OP_START     = 4'd6;
    localparam logic [3:0] OP_TOGGLE    = 4'd7;
    localparam logic [3:0] OP_TRIG_NEXT = 4'd8;
    localparam logic [3:0] OP_CHECK     = 4'd9;
    localparam logic [3:0] OP_CHECK_NOT = 4'd10;
    localparam logic [3:0] OP_CHECK_ON  = 4'd11;
    localparam logic [3:0] OP_FIRST     = 4'd12;
    localparam logic [3:0] OP_STATUS    = 4'd13;

    localparam logic REG_STOPPED_VALUE  = 1'b0;
    localparam logic REG_FIRST_RESPONSE = 1'b1;

    typedef struct packed {
        logic exec;
        logic div_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

// ===== src/itc_div.sv =====
module itc_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = shifted >= {1'b0, r_dvs};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[W-2:0], ge};
            n_rem = ge ? diff[W-1:0] : shifted[W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// ===== src/itc_dp.sv =====
module itc_dp #(
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itc_pkg::t_cmd i_cmd,
    output itc_pkg::t_sts o_sts,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic [3:0]    i_op,
    input  logic [31:0]   i_amount,
    input  logic          i_with_reset,
    input  logic          i_catch_up,
    output logic          o_answer,
    output logic          o_running,
    output logic [31:0]   o_elapsed,
    output logic [31:0]   o_remaining,
    output logic [31:0]   o_duration_out,
    output logic [31:0]   o_last_duration
);
    import itc_pkg::*;

    localparam int W = TIME_BITS;

    logic [W-1:0] r_now, n_now, r_start, n_start, r_stop, n_stop;
    logic [W-1:0] r_interval, n_interval, r_last, n_last;
    logic [31:0]  r_missed, n_missed;
    logic         r_running, n_running, r_armed, n_armed, r_fired, n_fired;
    logic         r_cu, n_cu;
    logic [31:0]  r_stopped_value;
    logic         r_first_resp;

    logic [W-1:0] amt, el, el_n, quo, rem;
    logic [W:0]   sum;
    logic         ge_int, trig, need_div, ans, load, div_done;
    logic [32:0]  mres;

    logic         r_answer, r_running_o;
    logic [31:0]  r_elapsed, r_remaining, r_duration, r_last_o;

    function automatic logic [32:0] f_missed(input logic [31:0] mc, input logic [63:0] q,
                                             input logic cu, input logic t);
        logic [31:0] qsat;
        logic [32:0] s;
        logic [31:0] m;
        qsat = (|q[63:32]) ? 32'hFFFF_FFFF : q[31:0];
        s    = {1'b0, mc} + {1'b0, qsat};
        m    = mc;
        if (cu) begin
            m = s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
        if (cu && (m != 32'd0)) begin
            return {1'b1, m - 32'd1};
        end
        return {t, m};
    endfunction

    itc_div #(.W(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (el),
        .i_divisor   (r_interval),
        .o_done      (div_done),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    always_comb begin
        amt      = W'(i_amount);
        el       = r_now - r_start;
        ge_int   = el >= r_interval;
        trig     = r_armed || ge_int;
        need_div = (i_op == OP_CHECK_ON) && trig && (r_interval != '0);
        sum      = {1'b0, r_interval} + {1'b0, amt};
        mres     = '0;
        ans        = 1'b0;
        n_now      = r_now;
        n_start    = r_start;
        n_stop     = r_stop;
        n_interval = r_interval;
        n_last     = r_last;
        n_missed   = r_missed;
        n_running  = r_running;
        n_armed    = r_armed;
        n_fired    = r_fired;
        n_cu       = r_cu;
        if (i_cmd.exec) begin
            case (i_op)
                OP_TICK: begin
                    n_now = r_now + 1'b1;
                end
                OP_SET, OP_ADD, OP_TAKE: begin
                    if (i_op == OP_SET) begin
                        n_interval = amt;
                    end else if (i_op == OP_ADD) begin
                        n_interval = sum[W] ? '1 : sum[W-1:0];
                    end else begin
                        n_interval = (amt > r_interval) ? '0 : r_interval - amt;
                    end
                    if (i_with_reset) begin
                        n_start = r_now;
                        n_armed = 1'b0;
                        n_fired = 1'b0;
                    end
                end
                OP_RESET: begin
                    n_start = r_now;
                    n_armed = 1'b0;
                    n_fired = 1'b0;
                end
                OP_STOP: begin
                    n_running = 1'b0;
                    n_stop    = r_now;
                end
                OP_START: begin
                    if (i_with_reset) begin
                        n_start = r_now;
                        n_armed = 1'b0;
                        n_fired = 1'b0;
                    end else if (!r_running) begin
                        n_start = r_start + r_now - r_stop;
                    end
                    n_running = 1'b1;
                end
                OP_TOGGLE: begin
                    n_running = !r_running;
                end
                OP_TRIG_NEXT: begin
                    n_armed = 1'b1;
                end
                OP_CHECK: begin
                    if (r_armed) begin
                        n_armed = 1'b0;
                    end else if (ge_int) begin
                        n_last = el;
                    end
                    if (i_with_reset && trig) begin
                        n_start = r_now;
                        n_armed = 1'b0;
                        n_fired = 1'b0;
                    end
                    ans = r_running && trig;
                end
                OP_CHECK_NOT: begin
                    if (r_running) begin
                        if (r_armed) begin
                            n_armed = 1'b0;
                        end else if (ge_int) begin
                            n_last = el;
                        end
                    end
                    ans = r_running && !trig;
                end
                OP_CHECK_ON: begin
                    if (r_armed) begin
                        n_armed = 1'b0;
                    end else if (ge_int) begin
                        n_last = el;
                    end
                    n_cu = i_catch_up;
                    if (trig && (r_interval == '0)) begin
                        n_start = r_now;
                        n_armed = 1'b0;
                        n_fired = 1'b0;
                    end
                    if (!need_div) begin
                        mres     = f_missed(r_missed, 64'd0, i_catch_up, trig);
                        n_missed = mres[31:0];
                        ans      = mres[32];
                    end
                end
                OP_FIRST: begin
                    if (r_fired) begin
                        ans = r_first_resp;
                    end else if (trig) begin
                        if (r_armed) begin
                            n_armed = 1'b0;
                        end else begin
                            n_last = el;
                        end
                        n_fired = 1'b1;
                        ans     = r_running;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.finish) begin
            mres     = f_missed(r_missed, 64'(quo), r_cu, 1'b1);
            n_missed = mres[31:0];
            ans      = mres[32];
            n_start  = r_now - rem;
            n_armed  = 1'b0;
            n_fired  = 1'b0;
        end
    end

    assign load = (i_cmd.exec && !need_div) || i_cmd.finish;
    assign el_n = n_now - n_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now           <= '0;
            r_start         <= '0;
            r_stop          <= '0;
            r_interval      <= '0;
            r_last          <= '0;
            r_missed        <= '0;
            r_running       <= 1'b1;
            r_armed         <= 1'b0;
            r_fired         <= 1'b0;
            r_cu            <= 1'b0;
            r_stopped_value <= '0;
            r_first_resp    <= 1'b0;
        end else begin
            r_now      <= n_now;
            r_start    <= n_start;
            r_stop     <= n_stop;
            r_interval <= n_interval;
            r_last     <= n_last;
            r_missed   <= n_missed;
            r_running  <= n_running;
            r_armed    <= n_armed;
            r_fired    <= n_fired;
            r_cu       <= n_cu;
            if (i_cfg_valid && (i_cfg_index == REG_STOPPED_VALUE)) begin
                r_stopped_value <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == REG_FIRST_RESPONSE)) begin
                r_first_resp <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_answer    <= ans;
            r_running_o <= n_running;
            r_elapsed   <= n_running ? 32'(el_n) : r_stopped_value;
            if (n_armed) begin
                r_remaining <= '0;
            end else if (!n_running) begin
                r_remaining <= r_stopped_value;
            end else begin
                r_remaining <= (el_n < n_interval) ? 32'(n_interval - el_n) : 32'd0;
            end
            r_duration  <= n_running ? 32'(n_interval) : r_stopped_value;
            r_last_o    <= 32'(n_last);
        end
    end

    assign o_sts.need_div  = need_div;
    assign o_sts.div_done  = div_done;
    assign o_answer        = r_answer;
    assign o_running       = r_running_o;
    assign o_elapsed       = r_elapsed;
    assign o_remaining     = r_remaining;
    assign o_duration_out  = r_duration;
    assign o_last_duration = r_last_o;
endmodule

// ===== src/itc_ctrl.sv =====
`include "interval_timer_with_catchup_core_macros.svh"

module itc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  itc_pkg::t_sts i_sts,
    output itc_pkg::t_cmd o_cmd
);
    import itc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    always_comb begin
        out_free      = !r_out_valid || !i_out_stall;
        o_in_stall    = (r_state != S_IDLE) || !out_free;
        cmd.exec      = i_in_valid && !o_in_stall;
        cmd.div_start = cmd.exec && i_sts.need_div;
        cmd.finish    = (r_state == S_FIN) && out_free;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd.div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if ((cmd.exec && !i_sts.need_div) || cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `ITC_ASSERT(a_div_entry, (r_state == S_DIV && $past(r_state) == S_IDLE) |-> $past(cmd.div_start), "divide entered without start")
    `ITC_ASSERT(a_finish_idle, cmd.finish |=> (r_state == S_IDLE && r_out_valid), "finish left no result")
    `ITC_NEVER(a_done_state, i_sts.div_done && (r_state != S_DIV), "divider done outside divide state")
endmodule

// ===== src/interval_timer_with_catchup_core.sv =====
// Interval timer with catch-up. Items enter on the i_in_* channel, one result beat leaves
// on o_out_* per item. Every op's result is registered. An on-duration check that fires
// with a nonzero duration first runs the elapsed count through a restoring divider, one
// quotient bit per cycle, before its result is registered. A new item is taken as soon
// as no divide is in progress and the output register is free or being drained.
// Configuration writes are always ready and are meant for idle periods.
module interval_timer_with_catchup_core #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_op,
    input  logic [31:0] i_amount,
    input  logic        i_with_reset,
    input  logic        i_catch_up,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_answer,
    output logic        o_running,
    output logic [31:0] o_elapsed,
    output logic [31:0] o_remaining,
    output logic [31:0] o_duration_out,
    output logic [31:0] o_last_duration
);
    import itc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    itc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    itc_dp #(.TIME_BITS(TIME_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_amount        (i_amount),
        .i_with_reset    (i_with_reset),
        .i_catch_up      (i_catch_up),
        .o_answer        (o_answer),
        .o_running       (o_running),
        .o_elapsed       (o_elapsed),
        .o_remaining     (o_remaining),
        .o_duration_out  (o_duration_out),
        .o_last_duration (o_last_duration)
    );
endmodule
